### hw/rtl/ialu_pkg.sv
package ialu_pkg;

  localparam int unsigned CmdWidth = 4;

  typedef enum logic [CmdWidth-1:0] {
    CmdUnion     = 4'd0,
    CmdIntersect = 4'd1,
    CmdInclude   = 4'd2,
    CmdAdd       = 4'd3,
    CmdSub       = 4'd4,
    CmdCircleAdd = 4'd5,
    CmdCircleSub = 4'd6,
    CmdValidate  = 4'd7,
    CmdLess      = 4'd8,
    CmdEqual     = 4'd9
  } cmd_e;

endpackage

### hw/rtl/ialu_core.sv
module ialu_core import ialu_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic [CmdWidth-1:0]           cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] a_left_i,
  input  logic signed [VALUE_WIDTH-1:0] a_right_i,
  input  logic                          a_left_open_i,
  input  logic                          a_right_open_i,
  input  logic signed [VALUE_WIDTH-1:0] b_left_i,
  input  logic signed [VALUE_WIDTH-1:0] b_right_i,
  input  logic                          b_left_open_i,
  input  logic                          b_right_open_i,
  output logic signed [VALUE_WIDTH-1:0] res_left_o,
  output logic signed [VALUE_WIDTH-1:0] res_right_o,
  output logic                          res_left_open_o,
  output logic                          res_right_open_o,
  output logic                          res_empty_o,
  output logic                          res_flag_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic signed [W-1:0] VMax     = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMin     = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MinusOne = {W{1'b1}};
  localparam logic signed [W:0]   VMaxExt  = {1'b0, VMax};
  localparam logic signed [W:0]   VMinExt  = {1'b1, VMin};

  // negation with swapped infinity codes
  function automatic logic signed [W-1:0] neg_v(input logic signed [W-1:0] x);
    logic signed [W-1:0] r;
    if (x == VMin) begin
      r = VMax;
    end else if (x == VMax) begin
      r = VMin;
    end else begin
      r = -x;
    end
    return r;
  endfunction

  function automatic logic opp_inf(input logic signed [W-1:0] x,
                                   input logic signed [W-1:0] y);
    return ((x == VMin) && (y == VMax)) || ((x == VMax) && (y == VMin));
  endfunction

  // saturating add, infinities absorb finite values
  function automatic logic signed [W-1:0] add_v(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    logic signed [W:0]   s;
    logic signed [W-1:0] r;
    s = {x[W-1], x} + {y[W-1], y};
    if ((x == VMin) || (y == VMin)) begin
      r = VMin;
    end else if ((x == VMax) || (y == VMax)) begin
      r = VMax;
    end else if (s >= VMaxExt) begin
      r = VMax;
    end else if (s <= VMinExt) begin
      r = VMin;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic valid_v(input logic signed [W-1:0] l,
                                   input logic signed [W-1:0] r,
                                   input logic lo,
                                   input logic ro);
    return !((l == r) && (lo || ro)) && !(l > r) && (l != VMax) && (r != VMin) &&
           !((l == VMin) && !lo) && !((r == VMax) && !ro);
  endfunction

  logic signed [W-1:0] x1, y1, x2, y2;
  logic                lflag, rflag;
  logic signed [W-1:0] sum_l, sum_r;
  logic                sum_bad;

  // union operands, ordered by left endpoint
  logic                swap;
  logic signed [W-1:0] p_l, p_r, q_l, q_r;
  logic                p_lo, p_ro, q_lo, q_ro;

  logic signed [W-1:0] r_l, r_r;
  logic                r_lo, r_ro, is_ivl, flag;

  // operand selection for the four sum-type commands
  always_comb begin
    x1    = a_left_i;
    x2    = a_right_i;
    y1    = b_left_i;
    y2    = b_right_i;
    lflag = a_left_open_i | b_left_open_i;
    rflag = a_right_open_i | b_right_open_i;
    unique case (cmd_e'(cmd_i))
      CmdSub: begin
        y1    = neg_v(b_right_i);
        y2    = neg_v(b_left_i);
        lflag = a_left_open_i | b_right_open_i;
        rflag = a_right_open_i | b_left_open_i;
      end
      CmdCircleAdd: begin
        y1    = b_right_i;
        y2    = b_left_i;
        lflag = a_left_open_i & !b_right_open_i;
        rflag = a_right_open_i & !b_left_open_i;
      end
      CmdCircleSub: begin
        y1    = neg_v(b_left_i);
        y2    = neg_v(b_right_i);
        lflag = a_left_open_i & !b_left_open_i;
        rflag = a_right_open_i & !b_right_open_i;
      end
      default: begin
      end
    endcase
  end

  assign sum_l   = add_v(x1, y1);
  assign sum_r   = add_v(x2, y2);
  assign sum_bad = opp_inf(x1, y1) | opp_inf(x2, y2);

  assign swap = a_left_i > b_left_i;
  assign p_l  = swap ? b_left_i       : a_left_i;
  assign p_r  = swap ? b_right_i      : a_right_i;
  assign p_lo = swap ? b_left_open_i  : a_left_open_i;
  assign p_ro = swap ? b_right_open_i : a_right_open_i;
  assign q_l  = swap ? a_left_i       : b_left_i;
  assign q_r  = swap ? a_right_i      : b_right_i;
  assign q_lo = swap ? a_left_open_i  : b_left_open_i;
  assign q_ro = swap ? a_right_open_i : b_right_open_i;

  always_comb begin
    r_l    = '0;
    r_r    = '0;
    r_lo   = 1'b0;
    r_ro   = 1'b0;
    is_ivl = 1'b1;
    flag   = 1'b0;
    unique case (cmd_e'(cmd_i))
      CmdUnion: begin
        if ((p_l != q_l) && ((q_l > p_r) || ((q_l == p_r) && q_lo && p_ro))) begin
          r_l  = MinusOne;
          r_r  = MinusOne;
          r_lo = 1'b1;
          r_ro = 1'b1;
        end else begin
          r_l  = p_l;
          r_lo = (p_l == q_l) ? (p_lo & q_lo) : p_lo;
          if (p_r == q_r) begin
            r_r  = p_r;
            r_ro = p_ro & q_ro;
          end else if (p_r > q_r) begin
            r_r  = p_r;
            r_ro = p_ro;
          end else begin
            r_r  = q_r;
            r_ro = q_ro;
          end
        end
      end
      CmdIntersect: begin
        if (a_left_i > b_left_i) begin
          r_l  = a_left_i;
          r_lo = a_left_open_i;
        end else if (a_left_i < b_left_i) begin
          r_l  = b_left_i;
          r_lo = b_left_open_i;
        end else begin
          r_l  = a_left_i;
          r_lo = a_left_open_i | b_left_open_i;
        end
        if (a_right_i < b_right_i) begin
          r_r  = a_right_i;
          r_ro = a_right_open_i;
        end else if (a_right_i > b_right_i) begin
          r_r  = b_right_i;
          r_ro = b_right_open_i;
        end else begin
          r_r  = a_right_i;
          r_ro = a_right_open_i | b_right_open_i;
        end
        if (!valid_v(r_l, r_r, r_lo, r_ro)) begin
          r_l  = MinusOne;
          r_r  = MinusOne;
          r_lo = 1'b1;
          r_ro = 1'b1;
        end
      end
      CmdAdd, CmdSub, CmdCircleAdd, CmdCircleSub: begin
        if (sum_bad) begin
          r_l  = MinusOne;
          r_r  = MinusOne;
          r_lo = 1'b1;
          r_ro = 1'b1;
        end else begin
          r_l  = sum_l;
          r_r  = sum_r;
          r_lo = (sum_l == VMin) | lflag;
          r_ro = (sum_r == VMax) | rflag;
        end
      end
      CmdInclude: begin
        is_ivl = 1'b0;
        flag   = !((a_left_i < b_left_i) || (a_right_i > b_right_i)) &&
                 !((a_left_i == b_left_i) && b_left_open_i && !a_left_open_i) &&
                 !((a_right_i == b_right_i) && b_right_open_i && !a_right_open_i);
      end
      CmdValidate: begin
        is_ivl = 1'b0;
        flag   = valid_v(a_left_i, a_right_i, a_left_open_i, a_right_open_i);
      end
      CmdLess: begin
        is_ivl = 1'b0;
        flag   = (a_left_i < b_left_i) ||
                 ((a_left_i == b_left_i) && (!a_left_open_i || b_left_open_i));
      end
      CmdEqual: begin
        is_ivl = 1'b0;
        flag   = (a_left_i == b_left_i) && (a_right_i == b_right_i) &&
                 (a_left_open_i == b_left_open_i) && (a_right_open_i == b_right_open_i);
      end
      default: begin
        is_ivl = 1'b0;
      end
    endcase
  end

  assign res_left_o       = r_l;
  assign res_right_o      = r_r;
  assign res_left_open_o  = r_lo;
  assign res_right_open_o = r_ro;
  assign res_empty_o      = is_ivl && (r_l == MinusOne) && (r_r == MinusOne) && r_lo && r_ro;
  assign res_flag_o       = flag;

endmodule

### hw/rtl/interval_alu.sv
// Interval ALU: one request carries a command and two intervals A and B, each with signed
// endpoints (most negative code = minus infinity, most positive = plus infinity) and an open
// flag per end, and returns exactly one result. A request is captured in an input register,
// evaluated by one pass of compare/add logic (ialu_core) and held in the result register, so
// out_valid_o rises once it has moved from the input register into the result register; a new
// request can be taken every cycle, and throughput is one request per cycle as long as
// out_stall_i stays low. The input side stalls only when both the input register and the
// result register are full and the output is stalled. No configuration, no state between
// requests, no clearing pass.
module interval_alu import ialu_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CmdWidth-1:0]           cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] a_left_i,
  input  logic signed [VALUE_WIDTH-1:0] a_right_i,
  input  logic                          a_left_open_i,
  input  logic                          a_right_open_i,
  input  logic signed [VALUE_WIDTH-1:0] b_left_i,
  input  logic signed [VALUE_WIDTH-1:0] b_right_i,
  input  logic                          b_left_open_i,
  input  logic                          b_right_open_i,
  // result side
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] res_left_o,
  output logic signed [VALUE_WIDTH-1:0] res_right_o,
  output logic                          res_left_open_o,
  output logic                          res_right_open_o,
  output logic                          res_empty_o,
  output logic                          res_flag_o
);

  localparam int unsigned W = VALUE_WIDTH;

  // input register
  logic                s1_valid_q, s1_valid_d;
  logic [CmdWidth-1:0] cmd_q;
  logic signed [W-1:0] a_left_q, a_right_q, b_left_q, b_right_q;
  logic                a_left_open_q, a_right_open_q, b_left_open_q, b_right_open_q;

  // result register
  logic                out_valid_q, out_valid_d;
  logic signed [W-1:0] res_left_q, res_right_q;
  logic                res_left_open_q, res_right_open_q, res_empty_q, res_flag_q;

  // core outputs
  logic signed [W-1:0] c_left, c_right;
  logic                c_left_open, c_right_open, c_empty, c_flag;

  logic out_free;  // result register can take a new value this cycle
  logic in_take;   // request accepted
  logic s1_move;   // input register moves into the result register

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !out_free);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q          <= cmd_i;
      a_left_q       <= a_left_i;
      a_right_q      <= a_right_i;
      a_left_open_q  <= a_left_open_i;
      a_right_open_q <= a_right_open_i;
      b_left_q       <= b_left_i;
      b_right_q      <= b_right_i;
      b_left_open_q  <= b_left_open_i;
      b_right_open_q <= b_right_open_i;
    end
  end

  ialu_core #(
    .VALUE_WIDTH(W)
  ) u_core (
    .cmd_i           (cmd_q),
    .a_left_i        (a_left_q),
    .a_right_i       (a_right_q),
    .a_left_open_i   (a_left_open_q),
    .a_right_open_i  (a_right_open_q),
    .b_left_i        (b_left_q),
    .b_right_i       (b_right_q),
    .b_left_open_i   (b_left_open_q),
    .b_right_open_i  (b_right_open_q),
    .res_left_o      (c_left),
    .res_right_o     (c_right),
    .res_left_open_o (c_left_open),
    .res_right_open_o(c_right_open),
    .res_empty_o     (c_empty),
    .res_flag_o      (c_flag)
  );

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_left_q       <= c_left;
      res_right_q      <= c_right;
      res_left_open_q  <= c_left_open;
      res_right_open_q <= c_right_open;
      res_empty_q      <= c_empty;
      res_flag_q       <= c_flag;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign res_left_o       = res_left_q;
  assign res_right_o      = res_right_q;
  assign res_left_open_o  = res_left_open_q;
  assign res_right_open_o = res_right_open_q;
  assign res_empty_o      = res_empty_q;
  assign res_flag_o       = res_flag_q;

endmodule
